// ===== rtl/fsq_pkg.sv =====
package fsq_pkg;

    localparam int unsigned SECTOR_CHUNK_COUNT_DEF = 4;
    localparam int unsigned MAX_CHUNKS_DEF = 256;

    localparam int unsigned CHUNK_W = 15;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned PAGES = 16;

    typedef enum logic [1:0] {
        OP_ERASE  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CRC    = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_REPORT  = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              abort;
        logic              any;
        logic [15:0]       fail_sum;
    } fail_upd_t;

endpackage

// ===== rtl/fsq_fail_update.sv =====
module fsq_fail_update (
    input  logic [fsq_pkg::WORD_W-1:0] word,
    input  logic [15:0]                mask,
    input  logic                       in_range,
    input  logic [15:0]                fail_sum,
    output fsq_pkg::fail_upd_t         upd
);

    logic [fsq_pkg::WORD_W-1:0] word_upd;
    logic [15:0] active;
    logic [15:0] hit;
    logic [4:0]  count;
    logic [16:0] sum;
    logic [15:0] sum_sat;

    always_comb begin
        logic       blocked;
        logic [3:0] c;
        blocked = 1'b0;
        word_upd = word;
        active = '0;
        hit = '0;
        for (int i = 0; i < 16; i++) begin
            c = word[4*i +: 4];
            active[i] = mask[i] & ~blocked;
            hit[i] = active[i] & in_range & (c == 4'd7);
            if (active[i] && c != 4'hF) begin
                word_upd[4*i +: 4] = c + 4'd1;
            end
            blocked = blocked | hit[i];
        end
    end

    assign count = 5'($countones(active));
    assign sum = {1'b0, fail_sum} + {12'b0, count};
    assign sum_sat = sum[16] ? 16'hFFFF : sum[15:0];
    assign upd = '{word: word_upd, abort: |hit, any: |mask, fail_sum: sum_sat};

endmodule

// ===== rtl/flash_upload_sequencer_top.sv =====
// Flash upload sequencer. When a transaction is accepted, the current chunk's packed failure-counter
// word is read from the counter memory into a register. The item is then evaluated, the updated
// word is written back (for an in-range report with a full written bitmap) and the result is loaded
// into the output register; evaluation waits while the output register holds a result not yet taken.
// No new item is accepted until the one in flight has been evaluated. After reset a clearing pass
// zeroes the counter memory, and no item is accepted during it. Configuration writes are always taken.
module flash_upload_sequencer_top #(
    parameter int unsigned SECTOR_CHUNK_COUNT = fsq_pkg::SECTOR_CHUNK_COUNT_DEF,
    parameter int unsigned MAX_CHUNKS = fsq_pkg::MAX_CHUNKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [11:0] s_report_first_page,
    input  logic [15:0] s_written_bitmap,
    input  logic [15:0] s_mismatch_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_operation,
    output logic [11:0] m_page_number,
    output logic        m_report_ok,
    output logic        m_finished,
    output logic [15:0] m_failure_total,
    output logic        m_misuse,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    localparam int unsigned CW = fsq_pkg::CHUNK_W;
    localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam logic [6:0] SCC_CIS = 7'(SECTOR_CHUNK_COUNT);
    localparam logic [CW-1:0] SCC_C = CW'(SECTOR_CHUNK_COUNT);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_CHUNKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CHUNKS - 1);

    logic [fsq_pkg::WORD_W-1:0] mem [MAX_CHUNKS];
    logic [fsq_pkg::WORD_W-1:0] rdata_reg;

    logic          clearing_reg;
    logic [AW-1:0] clear_addr_reg;
    logic [CW-1:0] eff_reg;
    logic          exec_valid_reg;

    logic        cmd_reg;
    logic [11:0] first_reg;
    logic [15:0] bitmap_reg;
    logic [15:0] mask_reg;

    logic [7:0]    sect_reg, sect_next;
    logic [5:0]    cis_reg, cis_next;
    logic          erase_reg, erase_next;
    logic [15:0]   map_reg, map_next;
    logic [4:0]    scan_reg, scan_next;
    logic [CW-1:0] cabs_reg, cabs_next;
    logic [CW-1:0] base_reg, base_next;
    logic [15:0]   fail_sum_reg, fail_sum_next;

    logic             m_valid_reg;
    fsq_pkg::op_t     op_reg, op_next;
    logic [11:0]      page_reg, page_next;
    logic             ok_reg, ok_next;
    logic             finished_reg, finished_next;
    logic             misuse_reg, misuse_next;

    logic s_fire;
    logic exec_go;
    logic wr_counts;

    logic [11:0]   chunk_page;
    logic          chunk_complete;
    logic          sector_complete;
    logic          all_complete;
    logic [7:0]    sector_inc;
    logic [CW-1:0] base_inc;
    logic [CW-1:0] cabs_inc;
    logic [16:0]   scan_sh;
    logic [15:0]   cand;
    logic [3:0]    pos;
    logic          in_range;
    logic [CW-1:0] cfg_ext;

    fsq_pkg::fail_upd_t upd;

    function automatic logic all_done(input logic [15:0] map, input logic [5:0] cis,
                                      input logic [CW-1:0] cabs, input logic [CW-1:0] base,
                                      input logic [CW-1:0] eff);
        logic last;
        last = (({1'b0, cis} + 7'd1) >= SCC_CIS) || ((cabs + CW'(1)) >= eff);
        return (map == 16'hFFFF) && last && ((base + SCC_C) >= eff);
    endfunction

    function automatic logic [3:0] lowest_set(input logic [15:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

    assign s_ready = ~clearing_reg & ~exec_valid_reg;
    assign s_fire = s_valid & s_ready;
    assign exec_go = exec_valid_reg & (~m_valid_reg | m_ready);
    assign cfg_ready = 1'b1;

    assign chunk_page = {cabs_reg[7:0], 4'b0};
    assign chunk_complete = (map_reg == 16'hFFFF);
    assign sector_complete = chunk_complete &&
        ((({1'b0, cis_reg} + 7'd1) >= SCC_CIS) || ((cabs_reg + CW'(1)) >= eff_reg));
    assign all_complete = all_done(map_reg, cis_reg, cabs_reg, base_reg, eff_reg);
    assign sector_inc = sect_reg + 8'd1;
    assign base_inc = (sect_reg == 8'hFF) ? '0 : base_reg + SCC_C;
    assign cabs_inc = cabs_reg + CW'(1);
    assign scan_sh = 17'h1FFFF << scan_reg;
    assign cand = ~map_reg & scan_sh[15:0];
    assign pos = lowest_set(cand);
    assign in_range = (cabs_reg < MAX_C);
    assign cfg_ext = CW'(cfg_data);

    fsq_fail_update u_fail_update (
        .word     (rdata_reg),
        .mask     (mask_reg),
        .in_range (in_range),
        .fail_sum (fail_sum_reg),
        .upd      (upd)
    );

    always_comb begin
        sect_next = sect_reg;
        cis_next = cis_reg;
        erase_next = erase_reg;
        map_next = map_reg;
        scan_next = scan_reg;
        cabs_next = cabs_reg;
        base_next = base_reg;
        fail_sum_next = fail_sum_reg;
        op_next = fsq_pkg::OP_ERASE;
        page_next = '0;
        ok_next = 1'b1;
        misuse_next = 1'b0;
        wr_counts = 1'b0;
        if (cmd_reg == fsq_pkg::CMD_REQUEST) begin
            priority if (all_complete) begin
                misuse_next = 1'b1;
            end else if (sector_complete) begin
                sect_next = sector_inc;
                cis_next = '0;
                base_next = base_inc;
                cabs_next = base_inc;
                map_next = '0;
                scan_next = '0;
                erase_next = 1'b1;
                page_next = {base_inc[7:0], 4'b0};
            end else if (!erase_reg) begin
                erase_next = 1'b1;
                page_next = chunk_page;
            end else if (chunk_complete) begin
                cis_next = cis_reg + 6'd1;
                cabs_next = cabs_inc;
                map_next = '0;
                scan_next = 5'd1;
                op_next = fsq_pkg::OP_WRITE;
                page_next = {cabs_inc[7:0], 4'b0};
            end else if (cand != '0) begin
                op_next = fsq_pkg::OP_WRITE;
                page_next = chunk_page + {8'b0, pos};
                scan_next = {1'b0, pos} + 5'd1;
            end else begin
                op_next = fsq_pkg::OP_CRC;
                page_next = chunk_page;
                scan_next = 5'd16;
            end
        end else begin
            op_next = fsq_pkg::OP_REPORT;
            page_next = chunk_page;
            if (first_reg != chunk_page) begin
                misuse_next = 1'b1;
            end else begin
                map_next = bitmap_reg;
                scan_next = '0;
                if (bitmap_reg == 16'hFFFF) begin
                    fail_sum_next = upd.fail_sum;
                    wr_counts = in_range;
                    if (upd.abort) begin
                        ok_next = 1'b0;
                    end else if (upd.any) begin
                        cis_next = '0;
                        erase_next = 1'b0;
                        map_next = '0;
                        cabs_next = base_reg;
                    end
                end
            end
        end
        finished_next = all_done(map_next, cis_next, cabs_next, base_next, eff_reg);
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clear_addr_reg] <= '0;
        end else if (exec_go && wr_counts) begin
            mem[cabs_reg[AW-1:0]] <= upd.word;
        end
        if (s_fire) begin
            rdata_reg <= mem[cabs_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_command;
            first_reg <= s_report_first_page;
            bitmap_reg <= s_written_bitmap;
            mask_reg <= s_mismatch_mask;
        end
        if (exec_go) begin
            op_reg <= op_next;
            page_reg <= page_next;
            ok_reg <= ok_next;
            finished_reg <= finished_next;
            misuse_reg <= misuse_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clear_addr_reg <= '0;
            eff_reg <= CW'(1);
            exec_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            sect_reg <= '0;
            cis_reg <= '0;
            erase_reg <= 1'b0;
            map_reg <= '0;
            scan_reg <= '0;
            cabs_reg <= '0;
            base_reg <= '0;
            fail_sum_reg <= '0;
        end else begin
            if (clearing_reg) begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
                if (clear_addr_reg == LAST_ADDR) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_valid) begin
                priority if (cfg_ext == '0) begin
                    eff_reg <= CW'(1);
                end else if (cfg_ext > MAX_C) begin
                    eff_reg <= MAX_C;
                end else begin
                    eff_reg <= cfg_ext;
                end
            end
            exec_valid_reg <= s_fire | (exec_valid_reg & ~exec_go);
            m_valid_reg <= exec_go | (m_valid_reg & ~m_ready);
            if (exec_go) begin
                sect_reg <= sect_next;
                cis_reg <= cis_next;
                erase_reg <= erase_next;
                map_reg <= map_next;
                scan_reg <= scan_next;
                cabs_reg <= cabs_next;
                base_reg <= base_next;
                fail_sum_reg <= fail_sum_next;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_operation = op_reg;
    assign m_page_number = page_reg;
    assign m_report_ok = ok_reg;
    assign m_finished = finished_reg;
    assign m_failure_total = fail_sum_reg;
    assign m_misuse = misuse_reg;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("item accepted during the counter clearing pass");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_valid_reg |-> !s_ready)
        else $error("new transaction accepted while one is still being evaluated");

    a_exec_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_go |=> m_valid)
        else $error("evaluated transaction did not reach the output register");

    a_abort_only_on_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_report_ok) |-> (m_operation == fsq_pkg::OP_REPORT))
        else $error("abort flagged on a result that is not a report");

    a_misuse_request_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_misuse && m_operation != fsq_pkg::OP_REPORT) |->
        (m_operation == fsq_pkg::OP_ERASE && m_page_number == 12'd0))
        else $error("request after finish must return erase at page zero");

endmodule
